// ===== hdl/arpc_pkg.sv =====
// Shared types and codes for the ARP cache and responder.
// Item structs, table entry struct, status and opcode codes, register indexes.
// No dependencies.
package arpc_pkg;

	localparam int DEFAULT_ENTRIES = 16;
	localparam int CFG_W           = 48;
	localparam int CFG_IDX_W       = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'd1;

	localparam logic [2:0] ST_IGNORED = 3'd0;
	localparam logic [2:0] ST_REPLIED = 3'd1;
	localparam logic [2:0] ST_LEARNED = 3'd2;
	localparam logic [2:0] ST_PRESENT = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_HIT     = 3'd5;
	localparam logic [2:0] ST_MISS    = 3'd6;

	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY   = 16'd2;

	typedef struct packed {
		logic        req_type;
		logic [15:0] arp_opcode;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [47:0] src_mac;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] query_ip;
	} arp_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] reply_hw_type;
		logic [15:0] reply_proto_type;
		logic [7:0]  reply_hw_len;
		logic [7:0]  reply_proto_len;
		logic [15:0] reply_opcode;
		logic [47:0] reply_src_mac;
		logic [31:0] reply_src_ip;
		logic [47:0] reply_dst_mac;
		logic [31:0] reply_dst_ip;
		logic [3:0]  slot_index;
		logic [47:0] found_mac;
	} arp_out_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] ip;
		logic [47:0] mac;
	} arpc_entry_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} arpc_cmd_t;

endpackage

// ===== hdl/arpc_table.sv =====
// Binding table: IP and MAC memories with a registered read port,
// plus a valid bit per slot cleared by reset. Depends on arpc_pkg.
module arpc_table #(
	parameter int TABLE_ENTRIES = arpc_pkg::DEFAULT_ENTRIES,
	parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  arpc_pkg::arpc_cmd_t   cmd,
	input  logic [IDX_W-1:0]      rd_addr,
	output arpc_pkg::arpc_entry_t rd_entry,
	input  logic [IDX_W-1:0]      wr_addr,
	input  arpc_pkg::arpc_entry_t wr_entry
);
	import arpc_pkg::*;

	logic [31:0]              ip_mem  [TABLE_ENTRIES];
	logic [47:0]              mac_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic                     rd_valid_q;
	logic [31:0]              rd_ip_q;
	logic [47:0]              rd_mac_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			ip_mem[wr_addr]  <= wr_entry.ip;
			mac_mem[wr_addr] <= wr_entry.mac;
		end
		if (cmd.rd_en) begin
			rd_ip_q  <= ip_mem[rd_addr];
			rd_mac_q <= mac_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_en)
				valid_q[wr_addr] <= wr_entry.valid;
			if (cmd.rd_en)
				rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_entry = '{valid: rd_valid_q, ip: rd_ip_q, mac: rd_mac_q};

endmodule

// ===== hdl/arpc_ctrl.sv =====
// Item sequencer: accepts an item, scans the table one slot per cycle,
// learns bindings, builds replies and holds the result register. Depends on arpc_pkg.
module arpc_ctrl #(
	parameter int TABLE_ENTRIES = arpc_pkg::DEFAULT_ENTRIES,
	parameter int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  arpc_pkg::arp_in_t     req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output arpc_pkg::arp_out_t    rsp,
	input  logic [31:0]           own_ip,
	input  logic [47:0]           own_mac,
	output arpc_pkg::arpc_cmd_t   cmd,
	output logic [IDX_W-1:0]      rd_addr,
	input  arpc_pkg::arpc_entry_t rd_entry,
	output logic [IDX_W-1:0]      wr_addr,
	output arpc_pkg::arpc_entry_t wr_entry
);
	import arpc_pkg::*;

	localparam int               CNT_W    = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_LEARN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             chk_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             lookup_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             rsp_valid_q;
	logic [31:0]      key_q;
	logic [47:0]      src_mac_q;
	arp_out_t         res_q;
	arp_out_t         rsp_q;

	logic accept;
	logic issue;
	logic hit;
	logic last;
	logic free_now;
	logic load;

	function automatic logic [3:0] slot4(input logic [IDX_W-1:0] idx);
		logic [IDX_W+3:0] ext;
		ext = {4'd0, idx};
		return ext[3:0];
	endfunction

	always_comb begin
		accept    = (state_q == S_IDLE) && req_valid;
		issue     = (state_q == S_SCAN) && (cnt_q < CNT_W'(TABLE_ENTRIES));
		hit       = (state_q == S_SCAN) && chk_s1 && rd_entry.valid && (rd_entry.ip == key_q);
		last      = (state_q == S_SCAN) && chk_s1 && (idx_s1 == LAST_IDX);
		free_now  = free_found_q || !rd_entry.valid;
		load      = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
		cmd.rd_en = issue;
		cmd.wr_en = (state_q == S_LEARN);
		rd_addr   = cnt_q[IDX_W-1:0];
		wr_addr   = free_idx_q;
		wr_entry  = '{valid: 1'b1, ip: key_q, mac: src_mac_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			chk_s1       <= 1'b0;
			lookup_q     <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q        <= '0;
						chk_s1       <= 1'b0;
						free_found_q <= 1'b0;
						lookup_q     <= req.req_type;
						if (req.req_type || req.arp_opcode == OP_REPLY)
							state_q <= S_SCAN;
						else
							state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					chk_s1 <= issue;
					if (issue)
						cnt_q <= cnt_q + CNT_W'(1);
					// remember the lowest free slot passed so far
					if (chk_s1 && !rd_entry.valid && !free_found_q)
						free_found_q <= 1'b1;
					if (hit) begin
						chk_s1  <= 1'b0;
						state_q <= S_DONE;
					end else if (last) begin
						chk_s1 <= 1'b0;
						if (!lookup_q && free_now)
							state_q <= S_LEARN;
						else
							state_q <= S_DONE;
					end
				end
				S_LEARN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q     <= '0;
			src_mac_q <= req.src_mac;
			key_q     <= req.req_type ? req.query_ip : req.src_ip;
			if (!req.req_type && req.arp_opcode == OP_REQUEST && req.dst_ip == own_ip) begin
				res_q.status           <= ST_REPLIED;
				res_q.reply_hw_type    <= req.hw_type;
				res_q.reply_proto_type <= req.proto_type;
				res_q.reply_hw_len     <= req.hw_len;
				res_q.reply_proto_len  <= req.proto_len;
				res_q.reply_opcode     <= OP_REPLY;
				res_q.reply_src_mac    <= own_mac;
				res_q.reply_src_ip     <= own_ip;
				res_q.reply_dst_mac    <= req.src_mac;
				res_q.reply_dst_ip     <= req.src_ip;
			end
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= rd_addr;
			if (chk_s1 && !rd_entry.valid && !free_found_q)
				free_idx_q <= idx_s1;
			if (hit) begin
				res_q.slot_index <= slot4(idx_s1);
				if (lookup_q) begin
					res_q.status    <= ST_HIT;
					res_q.found_mac <= rd_entry.mac;
				end else begin
					res_q.status <= ST_PRESENT;
				end
			end else if (last) begin
				if (lookup_q)
					res_q.status <= ST_MISS;
				else if (!free_now)
					res_q.status <= ST_FULL;
			end
		end
		if (state_q == S_LEARN) begin
			res_q.status     <= ST_LEARNED;
			res_q.slot_index <= slot4(free_idx_q);
		end
		if (load)
			rsp_q <= res_q;
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_learn_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LEARN |-> free_found_q)
		else $error("learn without a free slot");

	a_chk_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> $past(state_q) == S_SCAN)
		else $error("compare stage armed outside a scan");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.status <= ST_MISS)
		else $error("result status out of range");

	a_reply_opcode: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status == ST_REPLIED |-> rsp_q.reply_opcode == OP_REPLY)
		else $error("reply result without reply opcode");

endmodule

// ===== hdl/arp_cache_and_responder.sv =====
// ARP cache and responder, top level.
// ARP requests and ignored opcodes go from accept straight to the done state;
// lookups and ARP replies scan the table one slot per cycle through the
// memory read port before the result is loaded.
// Items are handled one at a time. Reset clears the valid bits and own addresses.
module arp_cache_and_responder #(
	parameter int TABLE_ENTRIES = arpc_pkg::DEFAULT_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  arpc_pkg::arp_in_t             req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output arpc_pkg::arp_out_t            rsp,
	input  logic                          cfg_we,
	input  logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [arpc_pkg::CFG_W-1:0]    cfg_wdata
);
	import arpc_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic [31:0]      own_ip_q;
	logic [47:0]      own_mac_q;
	arpc_cmd_t        cmd;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	arpc_entry_t      rd_entry;
	arpc_entry_t      wr_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OWN_IP:  own_ip_q  <= cfg_wdata[31:0];
				CFG_OWN_MAC: own_mac_q <= cfg_wdata[47:0];
				default: ;
			endcase
		end
	end

	arpc_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.own_ip(own_ip_q),
		.own_mac(own_mac_q),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.rd_entry(rd_entry),
		.wr_addr(wr_addr),
		.wr_entry(wr_entry)
	);

	arpc_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.IDX_W(IDX_W)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.rd_addr(rd_addr),
		.rd_entry(rd_entry),
		.wr_addr(wr_addr),
		.wr_entry(wr_entry)
	);

endmodule
